FILE: sv/mnca_pkg.sv
// Shared types and constants for the MIDI note channel allocator.
// No dependencies; imported by every module of the block.
package mnca_pkg;

   localparam int CHANNEL_COUNT_DEF = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_W       = 1;
   localparam int QUEUE_CNT_W       = 2;

   localparam logic [7:0]  STATUS_VOICE_LO = 8'h80;
   localparam logic [7:0]  STATUS_VOICE_HI = 8'hB0;
   localparam logic [13:0] BEND_CENTRE     = 14'd8192;

   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] KIND_TOUCH    = 4'hA;
   localparam logic [3:0] KIND_WHEEL    = 4'hE;

   typedef enum logic [2:0] {
      OP_PASS,
      OP_NOTE_ON,
      OP_NOTE_OFF,
      OP_TOUCH,
      OP_DROP
   } op_type;

   // One classified message waiting for the back end.
   typedef struct packed {
      op_type      op;
      logic [7:0]  status;
      logic [6:0]  data_one;  // raw data byte for pass-through, retuned note for voice
      logic [6:0]  data_two;
      logic [13:0] bend;
   } entry_type;

endpackage

FILE: sv/midi_note_channel_allocator.sv
// MIDI per-note channel allocator. Each transfer on the req_ port carries one
// short MIDI message and its retuned pitch; note-ons take the lowest free
// output channel (preceded by a pitch-wheel message when the bend is off
// centre), note-offs and poly aftertouch go to the channel holding the same
// pitch, and non-voice messages pass through unchanged. The front end takes
// one message per cycle into a two-entry queue while it has room; the back
// end retires one per cycle unless the result port stalls, holding a note-on
// with off-centre bend at the head while the single result register carries
// the pitch wheel and the note in turn. Unmapped or unroutable voice messages
// produce no result. Depends on mnca_pkg, mnca_front, mnca_queue, mnca_back.
module midi_note_channel_allocator
   import mnca_pkg::*;
#(
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_status_byte,
   input  logic [6:0]  req_data_one,
   input  logic [6:0]  req_data_two,
   input  logic        req_pitch_mapped,
   input  logic [6:0]  req_pitch_note,
   input  logic [13:0] req_pitch_bend,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_status,
   output logic [6:0]  rsp_out_data_one,
   output logic [6:0]  rsp_out_data_two,
   output logic        rsp_last
);

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      head_valid;
   logic      head_pop;
   entry_type head_entry;

   mnca_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_status_byte  (req_status_byte),
      .req_data_one     (req_data_one),
      .req_data_two     (req_data_two),
      .req_pitch_mapped (req_pitch_mapped),
      .req_pitch_note   (req_pitch_note),
      .req_pitch_bend   (req_pitch_bend),
      .push_valid       (push_valid),
      .push_entry       (push_entry),
      .push_ready       (push_ready)
   );

   mnca_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop)
   );

   mnca_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_status   (rsp_out_status),
      .rsp_out_data_one (rsp_out_data_one),
      .rsp_out_data_two (rsp_out_data_two),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: sv/mnca_front.sv
// Front end: classifies incoming messages and hands them to the queue.
// Depends on mnca_pkg.
module mnca_front
   import mnca_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_status_byte,
   input  logic [6:0]  req_data_one,
   input  logic [6:0]  req_data_two,
   input  logic        req_pitch_mapped,
   input  logic [6:0]  req_pitch_note,
   input  logic [13:0] req_pitch_bend,
   output logic        push_valid,
   output entry_type   push_entry,
   input  logic        push_ready
);

   op_type op;
   logic   is_voice;

   assign is_voice = (req_status_byte >= STATUS_VOICE_LO) &&
                     (req_status_byte <  STATUS_VOICE_HI);

   always_comb begin
      priority if (!is_voice) begin
         op = OP_PASS;
      end else if (!req_pitch_mapped) begin
         op = OP_DROP;
      end else if (req_status_byte[7:4] == KIND_NOTE_ON && req_data_two != 7'd0) begin
         op = OP_NOTE_ON;
      end else if (req_status_byte[7:4] == KIND_TOUCH) begin
         op = OP_TOUCH;
      end else begin
         // note-off, or note-on with zero velocity
         op = OP_NOTE_OFF;
      end
   end

   always_comb begin
      push_entry.op       = op;
      push_entry.status   = req_status_byte;
      push_entry.data_one = is_voice ? req_pitch_note : req_data_one;
      push_entry.data_two = req_data_two;
      push_entry.bend     = req_pitch_bend;
   end

   // dropped messages are taken and never queued
   assign req_ready  = push_ready;
   assign push_valid = req_valid && (op != OP_DROP);

endmodule

FILE: sv/mnca_queue.sv
// Short FIFO between the classifier and the channel allocation back end.
// Depends on mnca_pkg.
module mnca_queue
   import mnca_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      push_ready,
   output logic      head_valid,
   output entry_type head_entry,
   input  logic      head_pop
);

   entry_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = head_pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: sv/mnca_back.sv
// Back end: holds the per-channel pitch slots, allocates and frees
// channels and drives the registered result port. Depends on mnca_pkg.
module mnca_back
   import mnca_pkg::*;
#(
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       head_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_status,
   output logic [6:0] rsp_out_data_one,
   output logic [6:0] rsp_out_data_two,
   output logic       rsp_last
);

   localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   typedef enum logic {
      ST_FIRST,
      ST_SECOND
   } state_type;

   state_type          state_ff;
   logic [CH_W-1:0]    chan_ff;
   logic               busy_ff [CHANNEL_COUNT];
   logic [6:0]         note_ff [CHANNEL_COUNT];
   logic [13:0]        bend_ff [CHANNEL_COUNT];
   logic               rsp_valid_ff;
   logic [7:0]         rsp_status_ff;
   logic [6:0]         rsp_data_one_ff;
   logic [6:0]         rsp_data_two_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               step;
   logic               rsp_load;
   logic               free_hit;
   logic [CH_W-1:0]    free_ch;
   logic               match_hit;
   logic [CH_W-1:0]    match_ch;
   logic               bend_off_centre;
   logic [3:0]         kind;

   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign step            = out_free && head_valid;
   assign kind            = head_entry.status[7:4];
   assign bend_off_centre = (head_entry.bend != BEND_CENTRE);

   // lowest free channel and lowest matching busy channel
   always_comb begin
      free_hit  = 1'b0;
      free_ch   = '0;
      match_hit = 1'b0;
      match_ch  = '0;
      for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_hit = 1'b1;
            free_ch  = CH_W'(i);
         end
         if (busy_ff[i] && note_ff[i] == head_entry.data_one &&
             bend_ff[i] == head_entry.bend) begin
            match_hit = 1'b1;
            match_ch  = CH_W'(i);
         end
      end
   end

   // this step puts a new result into the output register
   assign rsp_load = step && ((state_ff == ST_SECOND) ||
                              (head_entry.op == OP_PASS) ||
                              (head_entry.op == OP_NOTE_ON && free_hit) ||
                              ((head_entry.op == OP_NOTE_OFF || head_entry.op == OP_TOUCH) &&
                               match_hit));

   // a note-on with off-centre bend stays at the queue head until ST_SECOND loads the note
   assign head_pop = step && !(state_ff == ST_FIRST && head_entry.op == OP_NOTE_ON &&
                               free_hit && bend_off_centre);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FIRST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            busy_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (step) begin
            unique case (state_ff)
               ST_SECOND: begin
                  rsp_status_ff   <= {kind, 4'(chan_ff)};
                  rsp_data_one_ff <= head_entry.data_one;
                  rsp_data_two_ff <= head_entry.data_two;
                  rsp_last_ff     <= 1'b1;
                  state_ff        <= ST_FIRST;
               end
               ST_FIRST: begin
                  unique case (head_entry.op)
                     OP_PASS: begin
                        rsp_status_ff   <= head_entry.status;
                        rsp_data_one_ff <= head_entry.data_one;
                        rsp_data_two_ff <= head_entry.data_two;
                        rsp_last_ff     <= 1'b1;
                     end
                     OP_NOTE_ON: begin
                        if (free_hit) begin
                           busy_ff[free_ch] <= 1'b1;
                           note_ff[free_ch] <= head_entry.data_one;
                           bend_ff[free_ch] <= head_entry.bend;
                           if (bend_off_centre) begin
                              rsp_status_ff   <= {KIND_WHEEL, 4'(free_ch)};
                              rsp_data_one_ff <= head_entry.bend[6:0];
                              rsp_data_two_ff <= head_entry.bend[13:7];
                              rsp_last_ff     <= 1'b0;
                              chan_ff         <= free_ch;
                              state_ff        <= ST_SECOND;
                           end else begin
                              rsp_status_ff   <= {kind, 4'(free_ch)};
                              rsp_data_one_ff <= head_entry.data_one;
                              rsp_data_two_ff <= head_entry.data_two;
                              rsp_last_ff     <= 1'b1;
                           end
                        end
                     end
                     OP_NOTE_OFF, OP_TOUCH: begin
                        if (match_hit) begin
                           if (head_entry.op == OP_NOTE_OFF) begin
                              busy_ff[match_ch] <= 1'b0;
                           end
                           rsp_status_ff   <= {kind, 4'(match_ch)};
                           rsp_data_one_ff <= head_entry.data_one;
                           rsp_data_two_ff <= head_entry.data_two;
                           rsp_last_ff     <= 1'b1;
                        end
                     end
                     default: begin
                        // dropped messages never reach the queue
                     end
                  endcase
               end
               default: state_ff <= ST_FIRST;
            endcase
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_status   = rsp_status_ff;
   assign rsp_out_data_one = rsp_data_one_ff;
   assign rsp_out_data_two = rsp_data_two_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

FILE: sv/mnca_checker.sv
// Port-level checks for the MIDI note channel allocator, bound to the top.
// Depends on mnca_pkg and midi_note_channel_allocator.
module mnca_checker
   import mnca_pkg::*;
#(
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_status,
   input logic [6:0] rsp_out_data_one,
   input logic [6:0] rsp_out_data_two,
   input logic       rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_status) &&
      $stable(rsp_out_data_one) && $stable(rsp_out_data_two) && $stable(rsp_last))
      else $error("result changed while stalled");

   // only a pitch wheel ahead of its note-on is not the last result
   a_first_is_wheel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_out_status[7:4] == KIND_WHEEL)
      else $error("non-final result is not a pitch wheel");

   // the note-on follows its pitch wheel at once, on the same channel
   a_wheel_then_note: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last &&
      rsp_out_status == {KIND_NOTE_ON, $past(rsp_out_status[3:0])})
      else $error("pitch wheel not followed by note-on on its channel");

   // voice results stay within the channel range
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_status >= STATUS_VOICE_LO) && (rsp_out_status < STATUS_VOICE_HI)
      |-> 32'(rsp_out_status[3:0]) < CHANNEL_COUNT)
      else $error("voice result on channel beyond range");

endmodule

bind midi_note_channel_allocator mnca_checker #(
   .CHANNEL_COUNT (CHANNEL_COUNT)
) u_mnca_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_status   (rsp_out_status),
   .rsp_out_data_one (rsp_out_data_one),
   .rsp_out_data_two (rsp_out_data_two),
   .rsp_last         (rsp_last)
);
